// File: rtl/dq_pkg.sv
// Shared types, constants and widths for the positional deque store.
package dq_pkg;

  localparam int CAPACITY  = 16;
  localparam int WORD_BITS = 32;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int POS_W = 5;
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  typedef enum logic [3:0] {
    OP_PUSH_BACK  = 4'd0,
    OP_PUSH_FRONT = 4'd1,
    OP_INSERT_AT  = 4'd2,
    OP_POP_BACK   = 4'd3,
    OP_POP_FRONT  = 4'd4,
    OP_REMOVE_AT  = 4'd5,
    OP_PEEK_FRONT = 4'd6,
    OP_PEEK_BACK  = 4'd7,
    OP_CLEAR      = 4'd8
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SEL_HOLD  = 2'd0,
    SEL_NEW   = 2'd1,
    SEL_LOWER = 2'd2,
    SEL_UPPER = 2'd3
  } sel_t;

  typedef struct packed {
    logic ins;
    logic del;
    idx_t idx;
  } shift_cmd_t;

  typedef struct packed {
    logic    read_valid;
    status_t status;
    idx_t    rd_idx;
    cnt_t    count_nxt;
  } ctrl_res_t;

endpackage

// File: rtl/dq_if.sv
// Request and response channel interfaces of the positional deque store.
interface dq_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  opcode;
  logic [4:0]  position;
  logic [31:0] data_word;

  modport source (output valid, output opcode, output position, output data_word, input ready);
  modport sink (input valid, input opcode, input position, input data_word, output ready);
endinterface

interface dq_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_word;
  logic        read_valid;
  logic [1:0]  status;
  logic [4:0]  entry_count;

  modport source (output valid, output read_word, output read_valid, output status,
                  output entry_count, input ready);
  modport sink (input valid, input read_word, input read_valid, input status,
                input entry_count, output ready);
endinterface

// File: rtl/dq_cell.sv
// One storage cell of the deque chain, loading from the request or a neighbor.
module dq_cell (
  input  logic          clk,
  input  dq_pkg::sel_t  sel,
  input  dq_pkg::word_t new_word,
  input  dq_pkg::word_t lower_word,
  input  dq_pkg::word_t upper_word,
  output dq_pkg::word_t word_r
);

  dq_pkg::word_t word_nxt;

  always_comb begin
    case (sel)
      dq_pkg::SEL_NEW:   word_nxt = new_word;
      dq_pkg::SEL_LOWER: word_nxt = lower_word;
      dq_pkg::SEL_UPPER: word_nxt = upper_word;
      default:           word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

endmodule

// File: rtl/dq_ctrl.sv
// Request decode, status checks and fill count of the deque store.
module dq_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  logic [3:0]            opcode,
  input  logic [4:0]            position,
  output dq_pkg::shift_cmd_t    cmd,
  output dq_pkg::ctrl_res_t     res
);

  dq_pkg::cnt_t                   count_r;
  dq_pkg::cnt_t                   count_nxt;
  logic [dq_pkg::CMP_W-1:0]       cnt_ext;
  logic [dq_pkg::CMP_W-1:0]       pos_ext;
  logic                           full;
  logic                           empty;
  dq_pkg::shift_cmd_t             cmd_raw;

  assign cnt_ext = dq_pkg::CMP_W'(count_r);
  assign pos_ext = dq_pkg::CMP_W'(position);
  assign full    = cnt_ext >= dq_pkg::CMP_W'(dq_pkg::CAPACITY);
  assign empty   = count_r == '0;

  always_comb begin
    cmd_raw        = '0;
    res.read_valid = 1'b0;
    res.status     = dq_pkg::ST_OK;
    res.rd_idx     = '0;
    count_nxt      = count_r;
    case (opcode)
      dq_pkg::OP_PUSH_BACK, dq_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          res.status = dq_pkg::ST_FULL;
        end else begin
          cmd_raw.ins = 1'b1;
          cmd_raw.idx = (opcode == dq_pkg::OP_PUSH_BACK) ? '0 : dq_pkg::IDX_W'(count_r);
          count_nxt   = count_r + dq_pkg::CNT_W'(1);
        end
      end
      dq_pkg::OP_INSERT_AT: begin
        if (pos_ext > cnt_ext + dq_pkg::CMP_W'(1)) begin
          res.status = dq_pkg::ST_BADPOS;
        end else if (full) begin
          res.status = dq_pkg::ST_FULL;
        end else begin
          cmd_raw.ins = 1'b1;
          cmd_raw.idx = (position == '0) ? '0 : dq_pkg::IDX_W'(pos_ext - dq_pkg::CMP_W'(1));
          count_nxt   = count_r + dq_pkg::CNT_W'(1);
        end
      end
      dq_pkg::OP_POP_BACK, dq_pkg::OP_POP_FRONT: begin
        if (empty) begin
          res.status = dq_pkg::ST_EMPTY;
        end else begin
          cmd_raw.del    = 1'b1;
          cmd_raw.idx    = (opcode == dq_pkg::OP_POP_BACK) ? '0 :
                           dq_pkg::IDX_W'(cnt_ext - dq_pkg::CMP_W'(1));
          res.rd_idx     = cmd_raw.idx;
          res.read_valid = 1'b1;
          count_nxt      = count_r - dq_pkg::CNT_W'(1);
        end
      end
      dq_pkg::OP_REMOVE_AT: begin
        if (empty) begin
          res.status = dq_pkg::ST_EMPTY;
        end else if (position == '0 || pos_ext > cnt_ext) begin
          res.status = dq_pkg::ST_BADPOS;
        end else begin
          cmd_raw.del    = 1'b1;
          cmd_raw.idx    = dq_pkg::IDX_W'(pos_ext - dq_pkg::CMP_W'(1));
          res.rd_idx     = cmd_raw.idx;
          res.read_valid = 1'b1;
          count_nxt      = count_r - dq_pkg::CNT_W'(1);
        end
      end
      dq_pkg::OP_PEEK_FRONT, dq_pkg::OP_PEEK_BACK: begin
        if (empty) begin
          res.status = dq_pkg::ST_EMPTY;
        end else begin
          res.read_valid = 1'b1;
          res.rd_idx     = (opcode == dq_pkg::OP_PEEK_BACK) ? '0 :
                           dq_pkg::IDX_W'(cnt_ext - dq_pkg::CMP_W'(1));
        end
      end
      dq_pkg::OP_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
      end
    endcase
    res.count_nxt = count_nxt;
    cmd.ins = cmd_raw.ins & fire;
    cmd.del = cmd_raw.del & fire;
    cmd.idx = cmd_raw.idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (fire) begin
      count_r <= count_nxt;
    end
  end

endmodule

// File: rtl/positional_deque_store_core.sv
// Top level of the positional deque store: cell chain, control and response register.
//
//   channel  direction  contents
//   in_req   in         opcode, position, data_word
//   out_rsp  out        read_word, read_valid, status, entry_count
//
// A request updates the cell chain directly: each cell that moves loads from the
// request or a neighbor and the rest hold; one request per cycle is accepted
// while the response is not stalled. The response is registered; a new request
// is taken while the last response is being taken or when the response register
// is empty. A stalled response holds the request side, and nothing else waits.
// Reset clears the fill count and the response valid; cell contents are
// undefined until written. No request is taken while reset is held.
module positional_deque_store_core (
  input  logic      clk,
  input  logic      rst_n,
  dq_req_if.sink    in_req,
  dq_rsp_if.source  out_rsp
);

  logic               fire;
  logic               rsp_valid_r;
  logic [31:0]        read_word_r;
  logic               read_valid_r;
  logic [1:0]         status_r;
  logic [4:0]         entry_count_r;
  dq_pkg::shift_cmd_t cmd;
  dq_pkg::ctrl_res_t  res;
  dq_pkg::word_t      new_word;
  dq_pkg::word_t      cell_word [dq_pkg::CAPACITY];
  dq_pkg::word_t      rd_word;

  assign in_req.ready = rst_n && (!rsp_valid_r || out_rsp.ready);
  assign fire         = in_req.valid && in_req.ready;
  assign new_word     = dq_pkg::WORD_BITS'(in_req.data_word);

  dq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .opcode   (in_req.opcode),
    .position (in_req.position),
    .cmd      (cmd),
    .res      (res)
  );

  for (genvar i = 0; i < dq_pkg::CAPACITY; i++) begin : g_cell
    localparam dq_pkg::idx_t CELL_IDX = dq_pkg::IDX_W'(i);
    dq_pkg::sel_t  sel;
    dq_pkg::word_t lower_word;
    dq_pkg::word_t upper_word;

    assign lower_word = (i == 0) ? cell_word[0] : cell_word[(i == 0) ? 0 : i - 1];
    assign upper_word = (i == dq_pkg::CAPACITY - 1) ? cell_word[i] :
                        cell_word[(i == dq_pkg::CAPACITY - 1) ? i : i + 1];

    always_comb begin
      sel = dq_pkg::SEL_HOLD;
      if (cmd.ins) begin
        if (CELL_IDX == cmd.idx) begin
          sel = dq_pkg::SEL_NEW;
        end else if (CELL_IDX > cmd.idx) begin
          sel = dq_pkg::SEL_LOWER;
        end
      end else if (cmd.del && CELL_IDX >= cmd.idx && i != dq_pkg::CAPACITY - 1) begin
        sel = dq_pkg::SEL_UPPER;
      end
    end

    dq_cell u_cell (
      .clk        (clk),
      .sel        (sel),
      .new_word   (new_word),
      .lower_word (lower_word),
      .upper_word (upper_word),
      .word_r     (cell_word[i])
    );
  end

  assign rd_word = cell_word[res.rd_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsp_valid_r <= 1'b0;
    end else if (fire) begin
      rsp_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      rsp_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      read_word_r   <= res.read_valid ? 32'(rd_word) : '0;
      read_valid_r  <= res.read_valid;
      status_r      <= res.status;
      entry_count_r <= 5'(res.count_nxt);
    end
  end

  assign out_rsp.valid       = rsp_valid_r;
  assign out_rsp.read_word   = read_word_r;
  assign out_rsp.read_valid  = read_valid_r;
  assign out_rsp.status      = status_r;
  assign out_rsp.entry_count = entry_count_r;

  a_full_count : assert property (@(posedge clk) disable iff (!rst_n)
    (rsp_valid_r && status_r == dq_pkg::ST_FULL) |->
      entry_count_r == 5'(dq_pkg::CAPACITY))
    else $error("full status with entry count below capacity");

  a_empty_count : assert property (@(posedge clk) disable iff (!rst_n)
    (rsp_valid_r && status_r == dq_pkg::ST_EMPTY) |-> entry_count_r == '0)
    else $error("empty status with nonzero entry count");

  a_read_ok : assert property (@(posedge clk) disable iff (!rst_n)
    (rsp_valid_r && read_valid_r) |-> status_r == dq_pkg::ST_OK)
    else $error("read word returned with a failing status");

  a_clear : assert property (@(posedge clk) disable iff (!rst_n)
    (fire && in_req.opcode == dq_pkg::OP_CLEAR) |=>
      (entry_count_r == '0 && status_r == dq_pkg::ST_OK))
    else $error("clear did not empty the store");

endmodule
